/* rtl/slec_pkg.sv */
// Shared types, constants and the set 1 key table for the scan code console.
// No dependencies; used by slec_core and scancode_line_editor_console_unit.
package slec_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;
  localparam int LINE_CAPACITY_DEF = 256;

  localparam int ADDR_W  = 11;
  localparam int CHAR_W  = 7;
  localparam int COLOR_W = 8;
  localparam int LEN_W   = 8;
  localparam int CODE_W  = 8;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  localparam logic [CHAR_W-1:0] KEY_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] KEY_BACK  = 7'h08;
  localparam logic [CHAR_W-1:0] KEY_ENTER = 7'h0A;
  localparam logic [CHAR_W-1:0] CHAR_PROMPT = 7'h3E;
  localparam logic [CHAR_W-1:0] CHAR_SPACE  = 7'h20;

  typedef struct packed {
    logic                 wr;
    logic [ADDR_W-1:0]    addr;
    logic [CHAR_W-1:0]    chr;
    logic [COLOR_W-1:0]   color;
    logic                 done;
    logic [LEN_W-1:0]     len;
  } res_t;

  function automatic logic [CHAR_W-1:0] slec_key(input logic [6:0] code);
    logic [CHAR_W-1:0] k;
    unique case (code)
      7'h01: k = 7'h1B;  7'h02: k = 7'h31;  7'h03: k = 7'h32;  7'h04: k = 7'h33;
      7'h05: k = 7'h34;  7'h06: k = 7'h35;  7'h07: k = 7'h36;  7'h08: k = 7'h37;
      7'h09: k = 7'h38;  7'h0A: k = 7'h39;  7'h0B: k = 7'h30;  7'h0C: k = 7'h2D;
      7'h0D: k = 7'h3D;  7'h0E: k = KEY_BACK; 7'h0F: k = 7'h09; 7'h10: k = 7'h71;
      7'h11: k = 7'h77;  7'h12: k = 7'h65;  7'h13: k = 7'h72;  7'h14: k = 7'h74;
      7'h15: k = 7'h79;  7'h16: k = 7'h75;  7'h17: k = 7'h69;  7'h18: k = 7'h6F;
      7'h19: k = 7'h70;  7'h1A: k = 7'h5B;  7'h1B: k = 7'h5D;  7'h1C: k = KEY_ENTER;
      7'h1E: k = 7'h61;  7'h1F: k = 7'h73;  7'h20: k = 7'h64;  7'h21: k = 7'h66;
      7'h22: k = 7'h67;  7'h23: k = 7'h68;  7'h24: k = 7'h6A;  7'h25: k = 7'h6B;
      7'h26: k = 7'h6C;  7'h27: k = 7'h3B;  7'h28: k = 7'h27;  7'h29: k = 7'h60;
      7'h2B: k = 7'h5C;  7'h2C: k = 7'h7A;  7'h2D: k = 7'h78;  7'h2E: k = 7'h63;
      7'h2F: k = 7'h76;  7'h30: k = 7'h62;  7'h31: k = 7'h6E;  7'h32: k = 7'h6D;
      7'h33: k = 7'h2C;  7'h34: k = 7'h2E;  7'h35: k = 7'h2F;  7'h37: k = 7'h2A;
      7'h39: k = CHAR_SPACE;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

/* rtl/slec_core.sv */
// Combinational step of the console: decodes one scan code against the cursor
// and line state and forms the next state and up to three result words. Uses slec_pkg.
module slec_core import slec_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
  localparam int ROW_W = $clog2(SCREEN_HEIGHT),
  localparam int COL_W = $clog2(SCREEN_WIDTH),
  localparam int LC_W  = $clog2(LINE_CAPACITY)
) (
  input  logic [CODE_W-1:0]  scan_code,
  input  logic [COLOR_W-1:0] color,
  input  logic [ROW_W-1:0]   row,
  input  logic [COL_W-1:0]   col,
  input  logic [LC_W-1:0]    lc,
  output logic [ROW_W-1:0]   row_nxt,
  output logic [COL_W-1:0]   col_nxt,
  output logic [LC_W-1:0]    lc_nxt,
  output logic [1:0]         cnt,
  output res_t [2:0]         res
);

  localparam int AW = ROW_W + COL_W;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(SCREEN_HEIGHT - 1);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(SCREEN_WIDTH - 1);
  localparam logic [COL_W-1:0] COL_ONE  = COL_W'(1);
  localparam logic [COL_W-1:0] COL_AFTER_PROMPT = COL_W'((SCREEN_WIDTH > 2) ? 2 : 0);
  localparam bit PROMPT_WRAPS = (SCREEN_WIDTH <= 2);
  localparam logic [LC_W-1:0] LC_FULL = LC_W'(LINE_CAPACITY - 1);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    logic [AW-1:0]        a;
    logic [AW+ADDR_W-1:0] wide;
    a    = AW'(r) * AW'(SCREEN_WIDTH) + AW'(c);
    wide = {{ADDR_W{1'b0}}, a};
    return wide[ADDR_W-1:0];
  endfunction

  logic [CHAR_W-1:0]     key;
  logic [ROW_W-1:0]      row_inc;
  logic [ROW_W-1:0]      row_inc2;
  logic [LC_W+LEN_W-1:0] len_wide;

  assign key      = slec_key(scan_code[6:0]);
  assign row_inc  = (row == ROW_LAST) ? '0 : row + ROW_W'(1);
  assign row_inc2 = (row_inc == ROW_LAST) ? '0 : row_inc + ROW_W'(1);
  assign len_wide = {{LEN_W{1'b0}}, lc};

  always_comb begin
    row_nxt = row;
    col_nxt = col;
    lc_nxt  = lc;
    cnt     = 2'd0;
    res     = '0;
    if (!scan_code[7] && key != KEY_NONE) begin
      if (key == KEY_ENTER) begin
        cnt          = 2'd3;
        lc_nxt       = '0;
        res[0].done  = 1'b1;
        res[0].len   = len_wide[LEN_W-1:0];
        res[1].wr    = 1'b1;
        res[1].addr  = cell_addr(row_inc, '0);
        res[1].chr   = CHAR_PROMPT;
        res[1].color = color;
        res[2].wr    = 1'b1;
        res[2].addr  = cell_addr(row_inc, COL_ONE);
        res[2].chr   = CHAR_SPACE;
        res[2].color = color;
        col_nxt      = COL_AFTER_PROMPT;
        row_nxt      = PROMPT_WRAPS ? row_inc2 : row_inc;
      end else if (key == KEY_BACK) begin
        if (lc != '0) begin
          lc_nxt = lc - LC_W'(1);
          if (col != '0) begin
            cnt          = 2'd1;
            col_nxt      = col - COL_ONE;
            res[0].wr    = 1'b1;
            res[0].addr  = cell_addr(row, col - COL_ONE);
            res[0].chr   = CHAR_SPACE;
            res[0].color = color;
          end
        end
      end else if (lc < LC_FULL) begin
        cnt          = 2'd1;
        lc_nxt       = lc + LC_W'(1);
        res[0].wr    = 1'b1;
        res[0].addr  = cell_addr(row, col);
        res[0].chr   = key;
        res[0].color = color;
        if (col == COL_LAST) begin
          col_nxt = '0;
          row_nxt = row_inc;
        end else begin
          col_nxt = col + COL_ONE;
        end
      end
    end
  end

endmodule

/* rtl/scancode_line_editor_console_unit.sv */
// Scan code line editor console: top level with stream ports and color register.
// Depends on slec_pkg and slec_core.
//
// Each accepted scan code word is registered, then decoded when the output buffer
// has room, and its results loaded into a three-word output buffer; a new word is
// taken every cycle as long as the buffer drains. Printable keys and backspace give
// at most one result word, so they sustain one code per cycle while the output is
// ready; Enter gives three result words, which leave one per cycle while the output
// is ready, and the input is held back until they have gone.
module scancode_line_editor_console_unit import slec_pkg::*; #(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] scan_code
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [39:0]  out_tdata,  // [0] cell_write, [11:1] cell_address,
                                   // [18:12] cell_char, [26:19] cell_color,
                                   // [27] line_done, [35:28] line_length
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data    // [7:0] text_color
);

  localparam int ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int COL_W = $clog2(SCREEN_WIDTH);
  localparam int LC_W  = $clog2(LINE_CAPACITY);

  logic               pend_r;
  logic [CODE_W-1:0]  scan_r;
  logic [COLOR_W-1:0] color_r;
  logic [ROW_W-1:0]   row_r;
  logic [COL_W-1:0]   col_r;
  logic [LC_W-1:0]    lc_r;
  res_t [2:0]         res_r;
  logic [1:0]         n_r;

  logic [ROW_W-1:0]   row_nxt;
  logic [COL_W-1:0]   col_nxt;
  logic [LC_W-1:0]    lc_nxt;
  logic [1:0]         cnt_nxt;
  res_t [2:0]         res_nxt;

  logic take;
  logic buf_free;
  logic proc;

  slec_core #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_core (
    .scan_code (scan_r),
    .color     (color_r),
    .row       (row_r),
    .col       (col_r),
    .lc        (lc_r),
    .row_nxt   (row_nxt),
    .col_nxt   (col_nxt),
    .lc_nxt    (lc_nxt),
    .cnt       (cnt_nxt),
    .res       (res_nxt)
  );

  assign take      = out_tvalid && out_tready;
  assign buf_free  = (n_r == 2'd0) || (n_r == 2'd1 && out_tready);
  assign proc      = pend_r && buf_free;
  assign in_tready = !pend_r || proc;
  assign cfg_ready = 1'b1;

  assign out_tvalid = (n_r != 2'd0);
  assign out_tlast  = (n_r == 2'd1);
  assign out_tdata  = {4'b0, res_r[0].len, res_r[0].done, res_r[0].color,
                       res_r[0].chr, res_r[0].addr, res_r[0].wr};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      color_r <= COLOR_RESET;
      row_r   <= '0;
      col_r   <= '0;
      lc_r    <= '0;
      n_r     <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        color_r <= cfg_data;
      end
      if (in_tvalid && in_tready) begin
        pend_r <= 1'b1;
      end else if (proc) begin
        pend_r <= 1'b0;
      end
      if (proc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        lc_r  <= lc_nxt;
        n_r   <= cnt_nxt;
      end else if (take) begin
        n_r <= n_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      scan_r <= in_tdata;
    end
    if (proc) begin
      res_r <= res_nxt;
    end else if (take) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_W'(SCREEN_WIDTH - 1))
    else $error("cursor column beyond the row");

  a_report_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r[0].done |-> !res_r[0].wr && !out_tlast)
    else $error("line report word writes a cell or ends the group");

  a_report_then_prompt: assert property (@(posedge clk) disable iff (!rst_n)
    take && res_r[0].done |=> out_tvalid && res_r[0].wr && res_r[0].chr == CHAR_PROMPT)
    else $error("line report not followed by the prompt");

endmodule

/* test/scancode_line_editor_console_unit_tb.sv */
// Self-checking testbench for scancode_line_editor_console_unit: a directed key table,
// then random typing sessions under three idle mixes. Depends on slec_pkg and the unit.
module scancode_line_editor_console_unit_tb;
  import slec_pkg::*;

  localparam int SCREEN_W      = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H      = SCREEN_HEIGHT_DEF;
  localparam int LINE_CAP      = LINE_CAPACITY_DEF;
  localparam int MAPPED_CODES  = 58;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SESSION_CODES = 8;

  localparam logic [7:0] SC_RELEASE = 8'h80;
  localparam logic [7:0] SC_ESC     = 8'h01;
  localparam logic [7:0] SC_BACK    = 8'h0E;
  localparam logic [7:0] SC_TAB     = 8'h0F;
  localparam logic [7:0] SC_ENTER   = 8'h1C;
  localparam logic [7:0] SC_SPACE   = 8'h39;

  localparam logic [6:0] KEYMAP [0:MAPPED_CODES-1] = '{
    KEY_NONE, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, KEY_BACK, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, KEY_ENTER, KEY_NONE, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, KEY_NONE, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, KEY_NONE, 7'h2A,
    KEY_NONE, CHAR_SPACE
  };

  typedef struct packed {
    logic        wr;
    logic [10:0] addr;
    logic [6:0]  chr;
    logic [7:0]  color;
    logic        done;
    logic [7:0]  len;
    logic        last;
  } screen_word_t;

  // A row with typed set carries its expected cell write (or none) for the reset color.
  typedef struct packed {
    logic [7:0]  code;
    logic        typed;
    logic [1:0]  nres;
    logic [10:0] addr;
    logic [6:0]  chr;
  } keystroke_row_t;

  localparam int KEY_ROWS = 25;
  keystroke_row_t keystroke_table [0:KEY_ROWS-1] = '{
    '{8'h9E,      1'b1, 2'd0, 11'd0,   7'h00},
    '{SC_BACK,    1'b1, 2'd0, 11'd0,   7'h00},
    '{8'h00,      1'b1, 2'd0, 11'd0,   7'h00},
    '{8'h7F,      1'b1, 2'd0, 11'd0,   7'h00},
    '{8'hFF,      1'b1, 2'd0, 11'd0,   7'h00},
    '{8'h1E,      1'b1, 2'd1, 11'd0,   7'h61},
    '{SC_ESC,     1'b1, 2'd1, 11'd1,   7'h1B},
    '{SC_TAB,     1'b1, 2'd1, 11'd2,   7'h09},
    '{SC_SPACE,   1'b1, 2'd1, 11'd3,   CHAR_SPACE},
    '{8'h37,      1'b1, 2'd1, 11'd4,   7'h2A},
    '{8'h35,      1'b1, 2'd1, 11'd5,   7'h2F},
    '{SC_BACK,    1'b1, 2'd1, 11'd5,   CHAR_SPACE},
    '{8'h8E,      1'b1, 2'd0, 11'd0,   7'h00},
    '{SC_ENTER,   1'b0, 2'd0, 11'd0,   7'h00},
    '{SC_BACK,    1'b1, 2'd0, 11'd0,   7'h00},
    '{8'h9C,      1'b1, 2'd0, 11'd0,   7'h00},
    '{8'h02,      1'b1, 2'd1, 11'd82,  7'h31},
    '{8'h0B,      1'b1, 2'd1, 11'd83,  7'h30},
    '{8'h2B,      1'b1, 2'd1, 11'd84,  7'h5C},
    '{SC_BACK,    1'b1, 2'd1, 11'd84,  CHAR_SPACE},
    '{SC_ENTER,   1'b0, 2'd0, 11'd0,   7'h00},
    '{SC_ENTER,   1'b0, 2'd0, 11'd0,   7'h00},
    '{8'h3A,      1'b1, 2'd0, 11'd0,   7'h00},
    '{8'h29,      1'b1, 2'd1, 11'd242, 7'h60},
    '{SC_RELEASE, 1'b1, 2'd0, 11'd0,   7'h00}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  scancode_line_editor_console_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  logic [7:0]     text_color;
  int             cursor_row;
  int             cursor_col;
  int             line_len;
  screen_word_t   console_words [0:2];
  screen_word_t   expected_words [$];
  keystroke_row_t active_row;

  int errors;
  int cycles;
  int codes_accepted;
  int words_checked;
  int lines_reported;
  int longest_line;
  int sender_idle_pct;
  int recv_idle_pct;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_words.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void next_console_row();
    cursor_col = 0;
    cursor_row++;
    if (cursor_row >= SCREEN_H) cursor_row = 0;
  endfunction

  function automatic screen_word_t cell_word(input logic [6:0] chr);
    screen_word_t w;
    w = '0;
    w.wr = 1'b1;
    w.addr = 11'(cursor_row * SCREEN_W + cursor_col);
    w.chr = chr;
    w.color = text_color;
    return w;
  endfunction

  function automatic void write_at_cursor(input int slot, input logic [6:0] chr);
    console_words[slot] = cell_word(chr);
    cursor_col++;
    if (cursor_col >= SCREEN_W) next_console_row();
  endfunction

  // Updates the console state for one scan code and returns the number of words it causes.
  function automatic int console_keystroke(input logic [7:0] code);
    logic [6:0] key;
    int n;
    n = 0;
    if (code[7] || code >= MAPPED_CODES) return 0;
    key = KEYMAP[code[6:0]];
    if (key == KEY_NONE) return 0;
    if (key == KEY_ENTER) begin
      next_console_row();
      console_words[0] = '0;
      console_words[0].done = 1'b1;
      console_words[0].len = line_len[7:0];
      line_len = 0;
      write_at_cursor(1, CHAR_PROMPT);
      write_at_cursor(2, CHAR_SPACE);
      n = 3;
    end else if (key == KEY_BACK) begin
      if (line_len > 0) begin
        line_len--;
        if (cursor_col > 0) begin
          cursor_col--;
          console_words[0] = cell_word(CHAR_SPACE);
          n = 1;
        end
      end
    end else if (line_len < LINE_CAP - 1) begin
      line_len++;
      write_at_cursor(0, key);
      n = 1;
    end
    if (n > 0) console_words[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    screen_word_t got;
    screen_word_t want;
    int n;
    if (rst_n && out_tvalid && out_tready) begin
      got.wr    = out_tdata[0];
      got.addr  = out_tdata[11:1];
      got.chr   = out_tdata[18:12];
      got.color = out_tdata[26:19];
      got.done  = out_tdata[27];
      got.len   = out_tdata[35:28];
      got.last  = out_tlast;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, actual %h", $time, got);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        check_field("cell_write", want.wr, got.wr);
        check_field("cell_address", want.addr, got.addr);
        check_field("cell_char", want.chr, got.chr);
        check_field("cell_color", want.color, got.color);
        check_field("line_done", want.done, got.done);
        check_field("line_length", want.len, got.len);
        check_field("last", want.last, got.last);
        if (got.done) begin
          lines_reported++;
          if (got.len > longest_line) longest_line = got.len;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      codes_accepted++;
      n = console_keystroke(in_tdata);
      if (active_row.typed) begin
        n = active_row.nres;
        want = '0;
        want.wr = 1'b1;
        want.addr = active_row.addr;
        want.chr = active_row.chr;
        want.color = COLOR_RESET;
        want.last = 1'b1;
        console_words[0] = want;
      end
      for (int i = 0; i < n; i++) expected_words.push_back(console_words[i]);
    end
  end

  task automatic push_code(input keystroke_row_t row);
    @(negedge clk);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    active_row = row;
    in_tvalid <= 1'b1;
    in_tdata <= row.code;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic push_plain(input logic [7:0] code);
    keystroke_row_t row;
    row = '0;
    row.code = code;
    push_code(row);
  endtask

  function automatic logic [7:0] pick_printable();
    logic [7:0] code;
    do code = 8'($urandom_range(1, MAPPED_CODES - 1));
    while (KEYMAP[code[6:0]] == KEY_NONE || KEYMAP[code[6:0]] == KEY_BACK ||
           KEYMAP[code[6:0]] == KEY_ENTER);
    return code;
  endfunction

  task automatic typing_session(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 54) push_plain(pick_printable());
      else if (pick < 64) push_plain(SC_BACK);
      else if (pick < 76) push_plain(SC_ENTER);
      else if (pick < 86) push_plain(SC_RELEASE | 8'($urandom_range(127)));
      else push_plain(8'($urandom_range(255)));
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_color(input logic [7:0] value);
    quiesce();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    text_color = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    active_row = '0;
    text_color = COLOR_RESET;
    cursor_row = 0;
    cursor_col = 0;
    line_len = 0;
    errors = 0;
    cycles = 0;
    codes_accepted = 0;
    words_checked = 0;
    lines_reported = 0;
    longest_line = 0;
    sender_idle_pct = 17;
    recv_idle_pct = 48;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < KEY_ROWS; i++) push_code(keystroke_table[i]);

    write_color(8'h00);
    typing_session(SESSION_CODES);
    // One long line wraps to the next row and backspaces into column zero.
    push_plain(SC_ENTER);
    repeat (79) push_plain(pick_printable());
    repeat (3) push_plain(SC_BACK);
    push_plain(SC_ENTER);

    write_color(8'hFF);
    sender_idle_pct = 48;
    recv_idle_pct = 17;
    typing_session(SESSION_CODES);

    write_color(8'($urandom_range(1, 254)));
    sender_idle_pct = 0;
    recv_idle_pct = 0;
    typing_session(SESSION_CODES);

    quiesce();
    $display("Run covered %0d scan codes and %0d result words under three idle mixes.",
             codes_accepted, words_checked);
    $display("It saw %0d line reports, the longest %0d characters, with four text colors.",
             lines_reported, longest_line);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* scancode_line_editor_console_unit.f */
rtl/slec_pkg.sv
rtl/slec_core.sv
rtl/scancode_line_editor_console_unit.sv
test/scancode_line_editor_console_unit_tb.sv
